[rtl/cle_pkg.sv]
`default_nettype none

package cle_pkg;

  // Byte codes with a meaning of their own, received or echoed
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_DEL  = 8'h7F;
  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_ETX  = 8'h03;
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_EOT  = 8'h04;
  localparam logic [7:0] BYTE_SP   = 8'h20;
  localparam logic [7:0] BYTE_LBR  = 8'h5B;
  localparam logic [7:0] BYTE_CUB  = 8'h44;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // What an accepted word turns into on the result side
  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_READ   = 3'd1,
    K_CHAR   = 3'd2,
    K_EOL    = 3'd3,
    K_DEL    = 3'd4,
    K_BS     = 3'd5,
    K_CANCEL = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
    logic [7:0] len;
    logic       closed;
    logic       rd_hit;
  } desc_t;

  function automatic logic [2:0] n_results_f(kind_t kind);
    logic [2:0] n;
    case (kind)
      K_DEL:   n = 3'd7;
      K_BS:    n = 3'd4;
      K_EOL:   n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_byte_f(kind_t kind, logic [7:0] rx, logic [2:0] step);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      K_CHAR:   b = rx;
      K_EOL:    b = (step == 3'd0) ? rx : BYTE_LF;
      K_CANCEL: b = BYTE_LF;
      K_DEL: begin
        case (step)
          3'd0, 3'd4: b = BYTE_ESC;
          3'd1, 3'd5: b = BYTE_LBR;
          3'd2, 3'd6: b = BYTE_CUB;
          default:    b = BYTE_SP;
        endcase
      end
      K_BS: begin
        case (step)
          3'd0:    b = BYTE_SP;
          3'd1:    b = BYTE_ESC;
          3'd2:    b = BYTE_LBR;
          default: b = BYTE_CUB;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/cle_if.sv]
`default_nettype none

interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic [6:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic [7:0] read_data;
  logic       line_done;
  logic       line_cancelled;
  logic [7:0] line_length;
  logic       last;

  modport source (output valid, echo_valid, echo_byte, read_data, line_done,
                  line_cancelled, line_length, last, input ready);
  modport sink   (input valid, echo_valid, echo_byte, read_data, line_done,
                  line_cancelled, line_length, last, output ready);
endinterface

`default_nettype wire

[rtl/console_line_editor.sv]
// Channel  Dir  Contents
// in_ch    in   cmd, rx_byte, read_index
// out_ch   out  echo_valid, echo_byte, read_data, line_done, line_cancelled,
//               line_length, last
//
// Each input word yields 1 to 7 result words, one per cycle, set by the echo
// sequencer's step counter (7 for delete, 4 for backspace, 2 for CR/LF, else 1).
// The next word is taken in the cycle the previous one's last result enters the
// output register, so single-result words flow at one per cycle.
// rst_n is synchronous, active low; it clears the line count and flags, the
// line memory is left as is. A stall on out_ch holds the output register and
// the sequencer, which in turn drops in_ch.ready.
`default_nettype none

module console_line_editor
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int IW = (CW > 7) ? CW : 7;

  logic [CW-1:0] char_count_r, char_count_nxt;
  logic          line_closed_r, line_closed_nxt;

  logic          seq_free, accept;
  desc_t         desc;
  logic          mem_we, mem_re;
  logic [7:0]    mem_q;
  logic [CW-1:0] cnt_eff;
  logic [IW-1:0] idx_ext, cnt_ext;

  assign in_ch.ready = seq_free;
  assign accept      = in_ch.valid && seq_free;

  // A closed line is emptied by the next received byte before it is handled
  assign cnt_eff = line_closed_r ? '0 : char_count_r;
  assign idx_ext = IW'(in_ch.read_index);
  assign cnt_ext = IW'(char_count_r);

  always_comb begin
    char_count_nxt  = char_count_r;
    line_closed_nxt = line_closed_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    desc.kind       = K_NONE;
    desc.rx_byte    = in_ch.rx_byte;
    desc.closed     = line_closed_r;
    desc.rd_hit     = (idx_ext < cnt_ext);
    if (in_ch.cmd == CMD_READ) begin
      desc.kind = K_READ;
      mem_re    = accept;
    end else begin
      char_count_nxt  = cnt_eff;
      line_closed_nxt = 1'b0;
      case (in_ch.rx_byte)
        BYTE_CR, BYTE_LF: begin
          desc.kind       = K_EOL;
          line_closed_nxt = 1'b1;
        end
        BYTE_DEL, BYTE_BS: begin
          if (cnt_eff != '0) begin
            desc.kind      = (in_ch.rx_byte == BYTE_DEL) ? K_DEL : K_BS;
            char_count_nxt = cnt_eff - CW'(1);
          end
        end
        BYTE_EOT, BYTE_ETX, BYTE_ESC: begin
          // Ctrl-D cancels only an empty line
          if (in_ch.rx_byte != BYTE_EOT || cnt_eff == '0) begin
            desc.kind       = K_CANCEL;
            char_count_nxt  = '0;
            line_closed_nxt = 1'b1;
          end
        end
        default: begin
          if (cnt_eff < CW'(LINE_CAPACITY)) begin
            desc.kind      = K_CHAR;
            char_count_nxt = cnt_eff + CW'(1);
            mem_we         = accept;
          end
        end
      endcase
    end
    desc.len = 8'(char_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r  <= '0;
      line_closed_r <= 1'b0;
    end else if (accept) begin
      char_count_r  <= char_count_nxt;
      line_closed_r <= line_closed_nxt;
    end
  end

  cle_line_mem #(
    .DEPTH (LINE_CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_eff[AW-1:0]),
    .wdata (in_ch.rx_byte),
    .re    (mem_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (mem_q)
  );

  cle_echo_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .desc_in (desc),
    .mem_q   (mem_q),
    .free    (seq_free),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[rtl/cle_line_mem.sv]
`default_nettype none

module cle_line_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/cle_echo_seq.sv]
`default_nettype none

module cle_echo_seq
  import cle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire desc_t      desc_in,
  input  wire logic [7:0] mem_q,
  output logic            free,
  cle_out_if.source       out_ch
);

  desc_t      desc_r;
  logic       desc_valid_r, desc_valid_nxt;
  logic [2:0] step_r, step_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       echo_valid_r, done_r, cancel_r, last_r;
  logic [7:0] echo_byte_r, read_data_r, len_r;

  logic issue, last_step;

  assign last_step = (step_r == n_results_f(desc_r.kind) - 3'd1);
  assign issue     = desc_valid_r && (!out_valid_r || out_ch.ready);
  assign free      = !desc_valid_r || (issue && last_step);

  always_comb begin
    desc_valid_nxt = desc_valid_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (issue) begin
      out_valid_nxt = 1'b1;
      step_nxt      = last_step ? 3'd0 : step_r + 3'd1;
      if (last_step) begin
        desc_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      desc_valid_nxt = 1'b1;
      step_nxt       = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
      step_r       <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: hold the descriptor, build one result word per issue
  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc_in;
    end
    if (issue) begin
      echo_valid_r <= (desc_r.kind != K_NONE) && (desc_r.kind != K_READ);
      echo_byte_r  <= echo_byte_f(desc_r.kind, desc_r.rx_byte, step_r);
      read_data_r  <= (desc_r.kind == K_READ && desc_r.rd_hit) ? mem_q : 8'h00;
      done_r       <= (desc_r.kind == K_READ) ? desc_r.closed :
                      (last_step && (desc_r.kind == K_EOL || desc_r.kind == K_CANCEL));
      cancel_r     <= (desc_r.kind == K_CANCEL);
      len_r        <= desc_r.len;
      last_r       <= last_step;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.echo_valid     = echo_valid_r;
  assign out_ch.echo_byte      = echo_byte_r;
  assign out_ch.read_data      = read_data_r;
  assign out_ch.line_done      = done_r;
  assign out_ch.line_cancelled = cancel_r;
  assign out_ch.line_length    = len_r;
  assign out_ch.last           = last_r;

endmodule

`default_nettype wire
